// ----- rtl/smac_pkg.sv -----
// Shared types and constants for the stack machine arithmetic core.
`default_nettype none
package smac_pkg;

   localparam int DATA_W = 32;
   localparam int OPC_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 7;
   localparam int DEFAULT_STACK_DEPTH = 64;

   // instruction codes
   localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPC_W-1:0] OP_ADD = 3'd1;
   localparam logic [OPC_W-1:0] OP_SUB = 3'd2;
   localparam logic [OPC_W-1:0] OP_DIV = 3'd3;
   localparam logic [OPC_W-1:0] OP_MUL = 3'd4;
   localparam logic [OPC_W-1:0] OP_MOD = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic signed [DATA_W-1:0] top_value;
      logic [COUNT_W-1:0] stack_count;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_result_type;

endpackage
`default_nettype wire

// ----- rtl/smac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/smac_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
`default_nettype none
module smac_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [smac_pkg::DATA_W-1:0] dividend,
   input wire logic [smac_pkg::DATA_W-1:0] divisor,
   output logic done,
   output smac_pkg::div_result_type result
);
   import smac_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic neg_q_ff, neg_q_in;
   logic neg_r_ff, neg_r_in;
   logic [DATA_W:0] trial;

   // partial remainder shifted left with the next dividend bit, minus divisor
   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in = dividend[DATA_W-1] ? -dividend : dividend;
         dvs_in = divisor[DATA_W-1] ? -divisor : divisor;
         rem_in = '0;
         neg_q_in = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_in = dividend[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done = done_ff;
   assign result.quotient = neg_q_ff ? -quo_ff : quo_ff;
   assign result.remainder = neg_r_ff ? -rem_ff : rem_ff;

endmodule
`default_nettype wire

// ----- rtl/stack_machine_arithmetic_core.sv -----
// Stack machine arithmetic core: bounded stack of 32-bit words with push and ALU ops.
// Sequence after accept: push, errors and unused opcodes go from idle to response;
//   add, sub, mul pass fetch and write-back; div, mod also run the 32-step divider.
// Throughput: one instruction at a time; the next beat is taken once the result has
//   moved into the output register. The iterative divider sets the worst case.
// Reset: synchronous, active high; clears entry count, sequencer and output valid.
//   Stack RAM contents are not cleared; only entries below the count are ever read.
`default_nettype none
module stack_machine_arithmetic_core #(
   parameter int STACK_DEPTH = smac_pkg::DEFAULT_STACK_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire smac_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output smac_pkg::rsp_type rsp_data
);
   import smac_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an instruction beat
   localparam logic [2:0] S_FETCH = 3'd1; // second operand arrives from RAM
   localparam logic [2:0] S_DIV = 3'd2;   // divider running
   localparam logic [2:0] S_WB = 3'd3;    // write result back, pop
   localparam logic [2:0] S_RESP = 3'd4;  // hand result to output register

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;     // cached copy of RAM[count-1]
   logic [DATA_W-1:0] res_ff, res_in;
   logic [OPC_W-1:0] op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic out_free;
   logic is_div_op;
   logic ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [DATA_W-1:0] second;
   logic div_start;
   logic div_done;
   div_result_type div_res;
   logic [ADDR_W-1:0] second_addr;

   assign req_stall = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_div_op = (req_data.opcode == OP_DIV) || (req_data.opcode == OP_MOD);
   assign second_addr = ADDR_W'(count_ff - CNT_W'(2));

   smac_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(second_addr),
      .rd_data(second)
   );

   smac_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(second),
      .divisor(top_ff),
      .done(div_done),
      .result(div_res)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in = top_ff;
      res_in = res_ff;
      op_in = op_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = second_addr;
      ram_wr_data = res_ff;
      ram_rd_en = 1'b0;
      div_start = 1'b0;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in = req_data.opcode;
               status_in = ST_OK;
               state_in = S_RESP;
               if (req_data.opcode == OP_PUSH) begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     ram_wr_addr = ADDR_W'(count_ff);
                     ram_wr_data = req_data.push_value;
                     top_in = req_data.push_value;
                     count_in = count_ff + 1'b1;
                  end
               end else if (req_data.opcode <= OP_MOD) begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = ST_SHORT;
                  end else if (is_div_op && (top_ff == '0)) begin
                     status_in = ST_DIVZERO;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            case (op_ff)
               OP_ADD: begin
                  res_in = second + top_ff;
                  state_in = S_WB;
               end
               OP_SUB: begin
                  res_in = second - top_ff;
                  state_in = S_WB;
               end
               OP_MUL: begin
                  // low word of the product is sign-agnostic
                  res_in = second * top_ff;
                  state_in = S_WB;
               end
               default: begin
                  div_start = 1'b1;
                  state_in = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in = (op_ff == OP_DIV) ? div_res.quotient : div_res.remainder;
               state_in = S_WB;
            end
         end
         S_WB: begin
            ram_wr_en = 1'b1;
            top_in = res_ff;
            count_in = count_ff - 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.top_value = (count_ff != '0) ? top_ff : '0;
               rsp_data_in.stack_count = COUNT_W'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff <= top_in;
      res_ff <= res_in;
      op_ff <= op_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire
